### rtl/grid_ray_caster_column_top_macros.svh
// ----------------------------------------------------------------------------
// Grid ray caster assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CASTER_COLUMN_TOP_MACROS_SVH
`define GRID_RAY_CASTER_COLUMN_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define GRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// Grid ray caster package
// Shared types, constants and helpers of the column ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

   // map and texture geometry
   localparam int MAP_DIM        = 64;
   localparam int TEXTURE_WIDTH  = 64;
   localparam int TEXTURE_HEIGHT = 64;
   localparam int IDX_W          = $clog2(MAP_DIM);
   localparam int ADDR_W         = $clog2(MAP_DIM * MAP_DIM);
   localparam int MX_W           = ((IDX_W > 6) ? IDX_W : 6) + 2;
   localparam int STEP_LIMIT     = 2 * MAP_DIM + 2;
   localparam int STEP_W         = $clog2(STEP_LIMIT + 1);
   localparam int TCOL_W         = $clog2(TEXTURE_WIDTH);

   // datapath widths
   localparam int CAM_W   = 30;
   localparam int RD_W    = 32;
   localparam int PROD_W  = 49;
   localparam int DXQ_W   = 33;
   localparam int SIDE_W  = 49;
   localparam int NS_W    = MX_W + 18;
   localparam int TSP_W   = 38;

   // shared divider
   localparam int DIV_NW = 48;
   localparam int DIV_DW = 32;
   localparam int DIV_CW = $clog2(DIV_NW + 1);
   localparam logic [DIV_CW-1:0] CAM_STEPS   = DIV_CW'(29);
   localparam logic [DIV_CW-1:0] RECIP_STEPS = DIV_CW'(33);
   localparam logic [DIV_CW-1:0] DIST_STEPS  = DIV_CW'(NS_W + 16);
   localparam logic [DIV_CW-1:0] LH_STEPS    = DIV_CW'(28);
   localparam logic [DIV_CW-1:0] TS_STEPS    = DIV_CW'($clog2(TEXTURE_HEIGHT) + 17);

   // saturation limits
   localparam logic [SIDE_W-1:0] SAT_SIDE = {1'b1, {(SIDE_W-1){1'b0}}};
   localparam logic [23:0] DIST_MAX  = 24'hFFFFFF;
   localparam logic [15:0] SLICE_MAX = 16'hFFFF;
   localparam logic [22:0] TSTEP_MAX = 23'd4194304;

   // configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DW    = 22;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_EYE_X         = 3'd2,
      CSR_EYE_Y         = 3'd3,
      CSR_LOOK_X        = 3'd4,
      CSR_LOOK_Y        = 3'd5,
      CSR_FOV_PLANE_X   = 3'd6,
      CSR_FOV_PLANE_Y   = 3'd7
   } grc_csr_type;

   typedef enum logic {
      CMD_WRITE_CELL = 1'b0,
      CMD_CAST       = 1'b1
   } grc_command_type;

   typedef struct packed {
      logic        command;
      logic [5:0]  cell_row;
      logic [5:0]  cell_col;
      logic        cell_solid;
      logic [10:0] column;
   } grc_req_type;

   typedef struct packed {
      logic [10:0] column_out;
      logic        hit_side;
      logic        escaped;
      logic        ray_x_negative;
      logic        ray_y_negative;
      logic [23:0] wall_distance;
      logic [15:0] slice_height;
      logic [10:0] draw_top;
      logic [10:0] draw_bottom;
      logic [5:0]  texture_column;
      logic [22:0] texture_step;
      logic [22:0] texture_start;
   } grc_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CAM_DIV, ST_RAY_MUL, ST_RAY_ADD, ST_DX_DIV, ST_DY_DIV,
      ST_SIDE, ST_WALK_STEP, ST_WALK_CHECK, ST_DIST_PREP, ST_DIST_DIV,
      ST_LH_DIV, ST_GEOM, ST_TS_DIV, ST_TSTART, ST_EMIT
   } grc_state_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_CAM_DIV, OP_RAY_MUL, OP_RAY_ADD, OP_DX_DIV, OP_DY_DIV,
      OP_SIDE, OP_WALK_STEP, OP_WALK_CHECK, OP_DIST_PREP, OP_DIST_DIV,
      OP_LH_DIV, OP_GEOM, OP_TS_DIV, OP_TSTART, OP_EMIT
   } grc_op_type;

   typedef struct packed {
      grc_op_type op;
      logic       div_start;
      logic       cell_write;
      logic       cast_capture;
   } grc_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic walk_done;
      logic escaped;
      logic out_free;
   } grc_status_type;

   // map coordinate lies inside the grid
   function automatic logic in_map(logic signed [MX_W-1:0] m);
      return !m[MX_W-1] && ($unsigned(m) < MX_W'(MAP_DIM));
   endfunction

endpackage

### rtl/grc_div.sv
// ----------------------------------------------------------------------------
// Grid ray caster divider
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div
   import grc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] num,
   input  logic [DIV_DW-1:0] den,
   input  logic [DIV_CW-1:0] steps,
   output logic              busy,
   output logic              done,
   output logic [DIV_NW-1:0] quot
);

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0] num_ff, num_in, quot_ff, quot_in;
   logic [DIV_DW-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [DIV_DW:0]   trial;
   logic              fits;

   // one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, num_ff[DIV_NW-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         num_in  = num << (DIV_CW'(DIV_NW) - steps);
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_DW'(trial - {1'b0, den_ff}) : DIV_DW'(trial);
         quot_in = {quot_ff[DIV_NW-2:0], fits};
         num_in  = num_ff << 1;
         cnt_in  = cnt_ff - DIV_CW'(1);
         if (cnt_ff == DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### rtl/grc_datapath.sv
// ----------------------------------------------------------------------------
// Grid ray caster datapath
// Settings, wall map, ray setup, grid walk, distance and texture math.
// ----------------------------------------------------------------------------
module grc_datapath
   import grc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DW-1:0]    csr_wdata,
   input  grc_req_type          req_payload,
   input  grc_cmd_type          cmd,
   output grc_status_type       status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output grc_rsp_type          rsp_payload
);

   // settings
   logic [11:0]        width_ff, height_ff;
   logic [21:0]        eye_x_ff, eye_y_ff;
   logic signed [18:0] look_x_ff, look_y_ff, fov_x_ff, fov_y_ff;

   // wall map
   logic               map_mem [MAP_DIM*MAP_DIM];
   logic               cell_ff;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;

   // cast state
   logic [10:0]              col_ff;
   logic signed [CAM_W-1:0]  cam_ff;
   logic signed [PROD_W-1:0] prodx_ff, prody_ff;
   logic signed [RD_W-1:0]   rdx_ff, rdy_ff;
   logic [SIDE_W-1:0]        dx_ff, dy_ff, sx_ff, sy_ff;
   logic signed [MX_W-1:0]   mx_ff, my_ff;
   logic                     side_ff, hit_ff, esc_ff;
   logic [STEP_W-1:0]        n_ff;
   logic [NS_W-1:0]          absnum_ff;
   logic [DIV_DW-1:0]        absrd_ff;
   logic [23:0]              dist_ff;
   logic [15:0]              lh_ff;
   logic [10:0]              top_ff, bot_ff;
   logic [15:0]              frac_ff;
   logic [22:0]              tstep_ff;
   logic [TSP_W-1:0]         tsprod_ff;
   logic                     rsp_valid_ff;
   grc_rsp_type              rsp_ff;

   // divider hookup
   logic [DIV_NW-1:0] div_num, div_quot;
   logic [DIV_DW-1:0] div_den;
   logic [DIV_CW-1:0] div_steps;
   logic              div_busy, div_done;

   // combinational helpers
   logic [11:0]             w_eff;
   logic [DIV_DW-1:0]       abs_rdx, abs_rdy;
   logic                    rdx_neg, rdy_neg, rdx_zero, rdy_zero;
   logic [16:0]             fx, fy;
   logic [SIDE_W:0]         mulx, muly, sx_sum, sy_sum;
   logic                    step_x;
   logic signed [MX_W-1:0]  nmx, nmy;
   logic signed [NS_W-1:0]  snum;
   logic [10:0]             hh;
   logic [14:0]             hlh, tdiff;
   logic [15:0]             bsum;
   logic [11:0]             blim;
   logic signed [56:0]      wprod;
   logic [TCOL_W+15:0]      tcol_wide;
   logic [TCOL_W-1:0]       tcol_raw, tcol;
   logic                    out_free;
   grc_rsp_type             rsp_in;

   grc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ray signs and magnitudes
   always_comb begin
      w_eff    = (width_ff == 12'd0) ? 12'd1 : width_ff;
      rdx_neg  = rdx_ff[RD_W-1];
      rdy_neg  = rdy_ff[RD_W-1];
      rdx_zero = rdx_ff == '0;
      rdy_zero = rdy_ff == '0;
      abs_rdx  = rdx_neg ? DIV_DW'(-rdx_ff) : DIV_DW'(rdx_ff);
      abs_rdy  = rdy_neg ? DIV_DW'(-rdy_ff) : DIV_DW'(rdy_ff);
   end

   // select divider operands
   always_comb begin
      div_num   = '0;
      div_den   = '0;
      div_steps = '0;
      unique case (cmd.op)
         OP_CAM_DIV: begin
            div_num   = DIV_NW'({col_ff, 17'd0});
            div_den   = DIV_DW'(w_eff);
            div_steps = CAM_STEPS;
         end
         OP_DX_DIV: begin
            div_num   = DIV_NW'(1) << 32;
            div_den   = abs_rdx;
            div_steps = RECIP_STEPS;
         end
         OP_DY_DIV: begin
            div_num   = DIV_NW'(1) << 32;
            div_den   = abs_rdy;
            div_steps = RECIP_STEPS;
         end
         OP_DIST_DIV: begin
            div_num   = DIV_NW'(absnum_ff) << 16;
            div_den   = absrd_ff;
            div_steps = DIST_STEPS;
         end
         OP_LH_DIV: begin
            div_num   = DIV_NW'(height_ff) << 16;
            div_den   = DIV_DW'(dist_ff);
            div_steps = LH_STEPS;
         end
         OP_TS_DIV: begin
            div_num   = DIV_NW'(TEXTURE_HEIGHT) << 16;
            div_den   = DIV_DW'(lh_ff);
            div_steps = TS_STEPS;
         end
         default: begin
            div_num   = '0;
         end
      endcase
   end

   // initial side distances and one walk step
   always_comb begin
      fx     = rdx_neg ? {1'b0, eye_x_ff[15:0]} : 17'h10000 - {1'b0, eye_x_ff[15:0]};
      fy     = rdy_neg ? {1'b0, eye_y_ff[15:0]} : 17'h10000 - {1'b0, eye_y_ff[15:0]};
      mulx   = (SIDE_W+1)'(fx) * (SIDE_W+1)'(dx_ff[DXQ_W-1:0]);
      muly   = (SIDE_W+1)'(fy) * (SIDE_W+1)'(dy_ff[DXQ_W-1:0]);
      step_x = sx_ff < sy_ff;
      sx_sum = (SIDE_W+1)'(sx_ff) + (SIDE_W+1)'(dx_ff);
      sy_sum = (SIDE_W+1)'(sy_ff) + (SIDE_W+1)'(dy_ff);
      nmx    = mx_ff;
      nmy    = my_ff;
      if (step_x) begin
         nmx = rdx_neg ? mx_ff - MX_W'(1) : mx_ff + MX_W'(1);
      end else begin
         nmy = rdy_neg ? my_ff - MX_W'(1) : my_ff + MX_W'(1);
      end
      rd_addr = ADDR_W'(nmx[IDX_W-1:0]) * ADDR_W'(MAP_DIM) + ADDR_W'(nmy[IDX_W-1:0]);
      wr_addr = ADDR_W'(req_payload.cell_row) * ADDR_W'(MAP_DIM)
              + ADDR_W'(req_payload.cell_col);
   end

   // boundary distance, slice rows and texture math
   always_comb begin
      if (!side_ff) begin
         snum = (NS_W'(mx_ff) <<< 16) - NS_W'($signed({1'b0, eye_x_ff}))
              + (rdx_neg ? NS_W'(65536) : NS_W'(0));
      end else begin
         snum = (NS_W'(my_ff) <<< 16) - NS_W'($signed({1'b0, eye_y_ff}))
              + (rdy_neg ? NS_W'(65536) : NS_W'(0));
      end
      hh    = height_ff[11:1];
      hlh   = lh_ff[15:1];
      bsum  = 16'(hlh) + 16'(hh);
      blim  = (height_ff != 12'd0) ? height_ff - 12'd1 : 12'd0;
      tdiff = (hlh > 15'(hh)) ? hlh - 15'(hh) : 15'd0;
      wprod = 57'($signed({1'b0, dist_ff})) * 57'(side_ff ? rdx_ff : rdy_ff);
      tcol_wide = (TCOL_W+16)'(frac_ff) * (TCOL_W+16)'(TEXTURE_WIDTH);
      tcol_raw  = tcol_wide[TCOL_W+15:16];
      if ((!side_ff && !rdx_neg && !rdx_zero) || (side_ff && rdy_neg)) begin
         tcol = TCOL_W'(TEXTURE_WIDTH - 1) - tcol_raw;
      end else begin
         tcol = tcol_raw;
      end
   end

   // assemble the result beat
   always_comb begin
      rsp_in                = '0;
      rsp_in.column_out     = col_ff;
      rsp_in.escaped        = esc_ff;
      rsp_in.ray_x_negative = rdx_neg;
      rsp_in.ray_y_negative = rdy_neg;
      if (!esc_ff) begin
         rsp_in.hit_side       = side_ff;
         rsp_in.wall_distance  = dist_ff;
         rsp_in.slice_height   = lh_ff;
         rsp_in.draw_top       = top_ff;
         rsp_in.draw_bottom    = bot_ff;
         rsp_in.texture_column = 6'(tcol);
         rsp_in.texture_step   = tstep_ff;
         rsp_in.texture_start  = (tsprod_ff > TSP_W'(TSTEP_MAX)) ? TSTEP_MAX
                                                                 : tsprod_ff[22:0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 12'd480;
         eye_x_ff  <= 22'd98304;
         eye_y_ff  <= 22'd98304;
         look_x_ff <= -19'sd65536;
         look_y_ff <= '0;
         fov_x_ff  <= '0;
         fov_y_ff  <= 19'sd43254;
      end else if (csr_wr_en) begin
         unique case (grc_csr_type'(csr_index))
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata[11:0];
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[11:0];
            CSR_EYE_X:         eye_x_ff  <= csr_wdata;
            CSR_EYE_Y:         eye_y_ff  <= csr_wdata;
            CSR_LOOK_X:        look_x_ff <= $signed(csr_wdata[18:0]);
            CSR_LOOK_Y:        look_y_ff <= $signed(csr_wdata[18:0]);
            CSR_FOV_PLANE_X:   fov_x_ff  <= $signed(csr_wdata[18:0]);
            CSR_FOV_PLANE_Y:   fov_y_ff  <= $signed(csr_wdata[18:0]);
            default:           width_ff  <= width_ff;
         endcase
      end
   end

   // wall map: one write port, one registered read
   always_ff @(posedge clock) begin
      if (cmd.cell_write && (32'(req_payload.cell_row) < MAP_DIM)
          && (32'(req_payload.cell_col) < MAP_DIM)) begin
         map_mem[wr_addr] <= req_payload.cell_solid;
      end
      cell_ff <= map_mem[rd_addr];
   end

   // cast pipeline registers, advanced by the controller's command
   always_ff @(posedge clock) begin
      if (cmd.cast_capture) begin
         col_ff <= req_payload.column;
      end
      case (cmd.op)
         OP_CAM_DIV: begin
            if (div_done) begin
               cam_ff <= $signed({1'b0, div_quot[CAM_W-2:0]}) - CAM_W'(65536);
            end
         end
         OP_RAY_MUL: begin
            prodx_ff <= PROD_W'(fov_x_ff) * PROD_W'(cam_ff);
            prody_ff <= PROD_W'(fov_y_ff) * PROD_W'(cam_ff);
         end
         OP_RAY_ADD: begin
            rdx_ff <= RD_W'(look_x_ff) + RD_W'(prodx_ff >>> 16);
            rdy_ff <= RD_W'(look_y_ff) + RD_W'(prody_ff >>> 16);
         end
         OP_DX_DIV: begin
            if (div_done) begin
               dx_ff <= SIDE_W'(div_quot[DXQ_W-1:0]);
            end
         end
         OP_DY_DIV: begin
            if (div_done) begin
               dy_ff <= SIDE_W'(div_quot[DXQ_W-1:0]);
            end
         end
         OP_SIDE: begin
            dx_ff   <= rdx_zero ? SAT_SIDE : dx_ff;
            dy_ff   <= rdy_zero ? SAT_SIDE : dy_ff;
            sx_ff   <= rdx_zero ? SAT_SIDE : SIDE_W'(mulx >> 16);
            sy_ff   <= rdy_zero ? SAT_SIDE : SIDE_W'(muly >> 16);
            mx_ff   <= MX_W'(eye_x_ff[21:16]);
            my_ff   <= MX_W'(eye_y_ff[21:16]);
            esc_ff  <= !in_map(MX_W'(eye_x_ff[21:16])) || !in_map(MX_W'(eye_y_ff[21:16]));
            hit_ff  <= 1'b0;
            side_ff <= 1'b0;
            n_ff    <= '0;
         end
         OP_WALK_STEP: begin
            if (step_x) begin
               sx_ff   <= (sx_sum > (SIDE_W+1)'(SAT_SIDE)) ? SAT_SIDE : SIDE_W'(sx_sum);
               side_ff <= 1'b0;
            end else begin
               sy_ff   <= (sy_sum > (SIDE_W+1)'(SAT_SIDE)) ? SAT_SIDE : SIDE_W'(sy_sum);
               side_ff <= 1'b1;
            end
            mx_ff <= nmx;
            my_ff <= nmy;
            n_ff  <= n_ff + STEP_W'(1);
         end
         OP_WALK_CHECK: begin
            if (!in_map(mx_ff) || !in_map(my_ff)) begin
               esc_ff <= 1'b1;
            end else if (cell_ff) begin
               hit_ff <= 1'b1;
            end
         end
         OP_DIST_PREP: begin
            esc_ff    <= esc_ff || !hit_ff;
            absnum_ff <= snum[NS_W-1] ? NS_W'(-snum) : NS_W'(snum);
            absrd_ff  <= side_ff ? abs_rdy : abs_rdx;
         end
         OP_DIST_DIV: begin
            if (div_done) begin
               dist_ff <= (div_quot > DIV_NW'(DIST_MAX)) ? DIST_MAX : div_quot[23:0];
            end
         end
         OP_LH_DIV: begin
            if (div_done) begin
               lh_ff <= (div_quot > DIV_NW'(SLICE_MAX)) ? SLICE_MAX : div_quot[15:0];
            end
         end
         OP_GEOM: begin
            top_ff <= (15'(hh) > hlh) ? hh - 11'(hlh) : 11'd0;
            if ((bsum > 16'(blim)) && (blim < 12'd2047)) begin
               bot_ff <= 11'(blim);
            end else if (bsum > 16'd2047) begin
               bot_ff <= 11'd2047;
            end else begin
               bot_ff <= 11'(bsum);
            end
            frac_ff <= (side_ff ? eye_x_ff[15:0] : eye_y_ff[15:0]) + wprod[31:16];
         end
         OP_TS_DIV: begin
            if (div_done) begin
               tstep_ff <= (div_quot > DIV_NW'(TSTEP_MAX)) ? TSTEP_MAX : div_quot[22:0];
            end
         end
         OP_TSTART: begin
            tsprod_ff <= TSP_W'(tdiff) * TSP_W'(tstep_ff);
         end
         default: begin
            n_ff <= n_ff;
         end
      endcase
   end

   // result register: load when free, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.op == OP_EMIT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if ((cmd.op == OP_EMIT) && out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.div_busy  = div_busy;
   assign status.div_done  = div_done;
   assign status.walk_done = esc_ff || hit_ff || (n_ff == STEP_W'(STEP_LIMIT));
   assign status.escaped   = esc_ff || !hit_ff;
   assign status.out_free  = out_free;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_ff;

endmodule

### rtl/grc_ctrl.sv
// ----------------------------------------------------------------------------
// Grid ray caster controller
// Sequences one cast through divisions, grid walk and result hand-off.
// ----------------------------------------------------------------------------
module grc_ctrl
   import grc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_command,
   output logic           req_stall,
   input  grc_status_type status,
   output grc_cmd_type    cmd
);

   grc_state_type state_ff, state_in;
   logic          div_run_ff, div_run_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_run_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         div_run_ff <= div_run_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in         = state_ff;
      div_run_in       = div_run_ff;
      cmd.op           = OP_IDLE;
      cmd.div_start    = 1'b0;
      cmd.cell_write   = 1'b0;
      cmd.cast_capture = 1'b0;
      req_stall        = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_command == CMD_CAST) begin
                  cmd.cast_capture = 1'b1;
                  state_in         = ST_CAM_DIV;
               end else begin
                  cmd.cell_write = 1'b1;
               end
            end
         end
         ST_CAM_DIV, ST_DX_DIV, ST_DY_DIV, ST_DIST_DIV, ST_LH_DIV, ST_TS_DIV: begin
            unique case (state_ff)
               ST_CAM_DIV:  cmd.op = OP_CAM_DIV;
               ST_DX_DIV:   cmd.op = OP_DX_DIV;
               ST_DY_DIV:   cmd.op = OP_DY_DIV;
               ST_DIST_DIV: cmd.op = OP_DIST_DIV;
               ST_LH_DIV:   cmd.op = OP_LH_DIV;
               default:     cmd.op = OP_TS_DIV;
            endcase
            // launch once, advance on completion
            if (!div_run_ff) begin
               cmd.div_start = 1'b1;
               div_run_in    = 1'b1;
            end else if (status.div_done) begin
               div_run_in = 1'b0;
               unique case (state_ff)
                  ST_CAM_DIV:  state_in = ST_RAY_MUL;
                  ST_DX_DIV:   state_in = ST_DY_DIV;
                  ST_DY_DIV:   state_in = ST_SIDE;
                  ST_DIST_DIV: state_in = ST_LH_DIV;
                  ST_LH_DIV:   state_in = ST_GEOM;
                  default:     state_in = ST_TSTART;
               endcase
            end
         end
         ST_RAY_MUL: begin
            cmd.op   = OP_RAY_MUL;
            state_in = ST_RAY_ADD;
         end
         ST_RAY_ADD: begin
            cmd.op   = OP_RAY_ADD;
            state_in = ST_DX_DIV;
         end
         ST_SIDE: begin
            cmd.op   = OP_SIDE;
            state_in = ST_WALK_STEP;
         end
         ST_WALK_STEP: begin
            if (status.walk_done) begin
               state_in = ST_DIST_PREP;
            end else begin
               cmd.op   = OP_WALK_STEP;
               state_in = ST_WALK_CHECK;
            end
         end
         ST_WALK_CHECK: begin
            cmd.op   = OP_WALK_CHECK;
            state_in = ST_WALK_STEP;
         end
         ST_DIST_PREP: begin
            cmd.op   = OP_DIST_PREP;
            state_in = status.escaped ? ST_EMIT : ST_DIST_DIV;
         end
         ST_GEOM: begin
            cmd.op   = OP_GEOM;
            state_in = ST_TS_DIV;
         end
         ST_TSTART: begin
            cmd.op   = OP_TSTART;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.op = OP_EMIT;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/grid_ray_caster_column_top.sv
// ----------------------------------------------------------------------------
// Grid ray caster, one screen column per cast
// Wall map store plus DDA grid walk with distance and texture results.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per beat. A cell write stores one map bit and
//   is taken with no result; back-to-back writes stream at one per cycle
//   while no cast is running. A cast produces exactly one rsp_* beat.
//   A cast runs through one shared radix-2 divider (camera, two reciprocals,
//   distance, slice height and texture step, each with a launch and a
//   hand-back) and a grid walk of a step state and a check state per cell,
//   the check following the registered map read. An escaped ray skips the
//   last three divisions. req_stall is high for the whole cast.
//   A finished result waits in the output register; the next item is taken
//   while it waits, and a cast only holds at its last step if the previous
//   result is still stalled there.
//   csr_* writes settings; write only while no cast is running.
//   Reset restores the default camera and screen settings and empties the
//   result register; the map content is undefined until written.
// ----------------------------------------------------------------------------
`include "grid_ray_caster_column_top_macros.svh"

module grid_ray_caster_column_top
   import grc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DW-1:0]    csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  grc_req_type          req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output grc_rsp_type          rsp_payload
);

   grc_cmd_type    cmd;
   grc_status_type status;

   grc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   grc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a taken cast keeps the input side closed next cycle
   `GRC_ASSERT_NEXT(a_cast_busy, req_valid && !req_stall && req_payload.command, req_stall, "cast did not hold input")
   // divider is never left running while the controller idles
   `GRC_ASSERT_NOW(a_div_idle, cmd.op == OP_IDLE && !req_stall, !status.div_busy, "divider busy in idle")
   // an escaped ray carries no distance or height
   `GRC_ASSERT_NOW(a_esc_zero, rsp_valid && rsp_payload.escaped, rsp_payload.wall_distance == 24'd0 && rsp_payload.slice_height == 16'd0, "escaped result not cleared")
   // slice rows are ordered
   `GRC_ASSERT_NOW(a_rows, rsp_valid, rsp_payload.draw_top <= rsp_payload.draw_bottom, "draw rows inverted")

endmodule

### bench/tb_grid_ray_caster_column_top.sv
// ----------------------------------------------------------------------------
// Grid ray caster column testbench
// Loads a walled room in the low corner of the map, then casts columns under
// several camera and screen settings with the eye inside the room. A
// scoreboard predicts every cast result with its own DDA walk in Q16 fixed
// point and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb_grid_ray_caster_column_top;
   import grc_pkg::*;

   localparam int    WATCHDOG_LIMIT = 20000;
   localparam int    HOLDOFF_CYCLES = 3000;
   localparam longint SIDE_SAT      = longint'(1) << 48;
   // room of written cells; its far row and column are solid walls
   localparam int    ROOM_DIM       = 12;
   localparam int    EYE_MAX        = (ROOM_DIM - 1) * 65536 - 1;

   // ------------------------------------------------------------------------
   // Column predictor and store of expected results
   // ------------------------------------------------------------------------
   class grc_scoreboard;
      bit          wall_map [MAP_DIM*MAP_DIM];
      longint      cfg [8];
      grc_rsp_type expected_cols [$];
      int          mismatches;
      int          casts_seen;
      int          escapes_seen;
      int          cells_written;

      function new();
         cfg[CSR_SCREEN_WIDTH]  = 640;
         cfg[CSR_SCREEN_HEIGHT] = 480;
         cfg[CSR_EYE_X]         = 98304;
         cfg[CSR_EYE_Y]         = 98304;
         cfg[CSR_LOOK_X]        = 'h80000 - 65536;
         cfg[CSR_LOOK_Y]        = 0;
         cfg[CSR_FOV_PLANE_X]   = 0;
         cfg[CSR_FOV_PLANE_Y]   = 43254;
      endfunction

      function void write_reg(grc_csr_type idx, longint val);
         if (idx <= CSR_SCREEN_HEIGHT) cfg[idx] = val & 'hFFF;
         else if (idx <= CSR_EYE_Y)    cfg[idx] = val & 'h3FFFFF;
         else                          cfg[idx] = val & 'h7FFFF;
      endfunction

      function longint q19(longint v);
         longint s;
         s = v & 'h7FFFF;
         if (s & 'h40000) s -= 'h80000;
         return s;
      endfunction

      function longint mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      // one DDA cast from the current camera
      function grc_rsp_type cast_column(logic [10:0] col);
         grc_rsp_type r;
         longint w, h, ex, ey, cam, rdx, rdy, dx, dy, sdx, sdy, mx, my, stx, sty, f;
         longint wall_dist, lh, top, bot, tcol, tstep, tstart, num, rd, wall, diff, lim;
         bit side, hit, esc;
         w  = cfg[CSR_SCREEN_WIDTH] != 0 ? cfg[CSR_SCREEN_WIDTH] : 1;
         h  = cfg[CSR_SCREEN_HEIGHT];
         ex = cfg[CSR_EYE_X];
         ey = cfg[CSR_EYE_Y];
         cam = ((2 * longint'(col)) << 16) / w - 65536;
         rdx = q19(cfg[CSR_LOOK_X]) + ((q19(cfg[CSR_FOV_PLANE_X]) * cam) >>> 16);
         rdy = q19(cfg[CSR_LOOK_Y]) + ((q19(cfg[CSR_FOV_PLANE_Y]) * cam) >>> 16);
         mx = ex >> 16;
         my = ey >> 16;
         stx = rdx < 0 ? -1 : 1;
         sty = rdy < 0 ? -1 : 1;
         if (rdx == 0) begin
            dx = SIDE_SAT; sdx = SIDE_SAT;
         end else begin
            f = rdx < 0 ? (ex & 'hFFFF) : 65536 - (ex & 'hFFFF);
            dx = (longint'(1) << 32) / mag(rdx);
            sdx = (f * dx) >>> 16;
         end
         if (rdy == 0) begin
            dy = SIDE_SAT; sdy = SIDE_SAT;
         end else begin
            f = rdy < 0 ? (ey & 'hFFFF) : 65536 - (ey & 'hFFFF);
            dy = (longint'(1) << 32) / mag(rdy);
            sdy = (f * dy) >>> 16;
         end
         side = 0; hit = 0;
         esc = !(mx >= 0 && mx < MAP_DIM && my >= 0 && my < MAP_DIM);
         // walk the grid; the eye cell itself is never tested
         for (int n = 0; !esc && !hit && n < 2*MAP_DIM + 2; n++) begin
            if (sdx < sdy) begin
               sdx += dx; if (sdx > SIDE_SAT) sdx = SIDE_SAT;
               mx += stx; side = 0;
            end else begin
               sdy += dy; if (sdy > SIDE_SAT) sdy = SIDE_SAT;
               my += sty; side = 1;
            end
            if (!(mx >= 0 && mx < MAP_DIM && my >= 0 && my < MAP_DIM)) esc = 1;
            else if (wall_map[mx*MAP_DIM + my]) hit = 1;
         end
         if (!hit) esc = 1;
         wall_dist = 0; lh = 0; top = 0; bot = 0; tcol = 0; tstep = 0; tstart = 0;
         if (!esc) begin
            if (side == 0) begin
               num = mx*65536 - ex + (stx < 0 ? 65536 : 0); rd = rdx;
            end else begin
               num = my*65536 - ey + (sty < 0 ? 65536 : 0); rd = rdy;
            end
            wall_dist = rd == 0 ? longint'(DIST_MAX) : (mag(num) << 16) / mag(rd);
            if (wall_dist > DIST_MAX) wall_dist = DIST_MAX;
            lh = wall_dist == 0 ? longint'(SLICE_MAX) : (h << 16) / wall_dist;
            if (lh > SLICE_MAX) lh = SLICE_MAX;
            diff = h/2 - lh/2;
            top = diff < 0 ? 0 : diff;
            bot = lh/2 + h/2;
            lim = h > 0 ? h - 1 : 0;
            if (bot > lim) bot = lim;
            if (bot > 2047) bot = 2047;
            if (side == 0) wall = ey + ((wall_dist * rdy) >>> 16);
            else           wall = ex + ((wall_dist * rdx) >>> 16);
            tcol = ((wall & 'hFFFF) * TEXTURE_WIDTH) >> 16;
            if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0))
               tcol = TEXTURE_WIDTH - tcol - 1;
            tstep = lh == 0 ? longint'(TSTEP_MAX) : (longint'(TEXTURE_HEIGHT) << 16) / lh;
            if (tstep > TSTEP_MAX) tstep = TSTEP_MAX;
            diff = top - h/2 + lh/2;
            if (diff < 0) diff = 0;
            tstart = diff * tstep;
            if (tstart > TSTEP_MAX) tstart = TSTEP_MAX;
         end
         r.column_out     = col;
         r.hit_side       = esc ? 1'b0 : side;
         r.escaped        = esc;
         r.ray_x_negative = rdx < 0;
         r.ray_y_negative = rdy < 0;
         r.wall_distance  = wall_dist[23:0];
         r.slice_height   = lh[15:0];
         r.draw_top       = top[10:0];
         r.draw_bottom    = bot[10:0];
         r.texture_column = tcol[5:0];
         r.texture_step   = tstep[22:0];
         r.texture_start  = tstart[22:0];
         return r;
      endfunction

      // note one accepted request beat
      function void note_request(grc_req_type q);
         if (q.command == CMD_WRITE_CELL) begin
            wall_map[q.cell_row*MAP_DIM + q.cell_col] = q.cell_solid;
            cells_written++;
         end else begin
            expected_cols.push_back(cast_column(q.column));
         end
      endfunction

      function void field(string name, logic [23:0] exp_v, logic [23:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
         end
      endfunction

      // compare one result beat with the oldest expectation
      function void check_result(grc_rsp_type a);
         grc_rsp_type e;
         if (expected_cols.size() == 0) begin
            $error("result beat for column %0d with nothing expected", a.column_out);
            mismatches++;
            return;
         end
         e = expected_cols.pop_front();
         casts_seen++;
         if (e.escaped) escapes_seen++;
         field("column_out",     e.column_out,     a.column_out);
         field("hit_side",       e.hit_side,       a.hit_side);
         field("escaped",        e.escaped,        a.escaped);
         field("ray_x_negative", e.ray_x_negative, a.ray_x_negative);
         field("ray_y_negative", e.ray_y_negative, a.ray_y_negative);
         field("wall_distance",  e.wall_distance,  a.wall_distance);
         field("slice_height",   e.slice_height,   a.slice_height);
         field("draw_top",       e.draw_top,       a.draw_top);
         field("draw_bottom",    e.draw_bottom,    a.draw_bottom);
         field("texture_column", e.texture_column, a.texture_column);
         field("texture_step",   e.texture_step,   a.texture_step);
         field("texture_start",  e.texture_start,  a.texture_start);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DW-1:0]    csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   grc_req_type          req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   grc_rsp_type          rsp_payload;

   grc_scoreboard sb;
   bit            no_idle;
   int            holdoff;
   int            quiet_cycles;

   grid_ray_caster_column_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // receive result beats and stall at random, or hold off on request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
         if (holdoff > 0) begin
            holdoff--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 20);
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one beat and hold it until taken, then maybe idle
   task automatic send(input grc_req_type q);
      int gap;
      req_payload <= q;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(q);
      gap = (!no_idle && $urandom_range(99) < 20) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_cell(input int row, input int col, input bit solid);
      grc_req_type q;
      q = $bits(grc_req_type)'($urandom);
      q.command    = CMD_WRITE_CELL;
      q.cell_row   = 6'(row);
      q.cell_col   = 6'(col);
      q.cell_solid = solid;
      send(q);
   endtask

   task automatic send_cast(input int col);
      grc_req_type q;
      q = $bits(grc_req_type)'($urandom);
      q.command = CMD_CAST;
      q.column  = 11'(col);
      send(q);
   endtask

   // drain all results, then write a full camera and screen setting
   task automatic set_camera(input longint vals [8]);
      req_valid <= 1'b0;
      while (sb.expected_cols.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= grc_csr_type'(i);
         csr_wdata <= vals[i][CSR_DW-1:0];
         @(posedge clock);
         sb.write_reg(grc_csr_type'(i), vals[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_column_cast();
      longint w;
      w = sb.cfg[CSR_SCREEN_WIDTH] != 0 ? sb.cfg[CSR_SCREEN_WIDTH] : 1;
      if ($urandom_range(99) < 90) send_cast($urandom_range(w > 2048 ? 2047 : w - 1));
      else                         send_cast($urandom_range(2047));
   endtask

   function automatic longint rnd_signed(int lim);
      return longint'($urandom_range(2*lim)) - lim;
   endfunction

   initial begin
      longint vals [8];
      sb = new();
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= CSR_SCREEN_WIDTH;
      csr_wdata   <= '0;
      req_valid   <= 1'b0;
      req_payload <= '0;
      rsp_stall   <= 1'b0;
      no_idle = 0;
      holdoff = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load the room before the first cast; rays leave it only off the map
      for (int x = 0; x < ROOM_DIM; x++)
         for (int y = 0; y < ROOM_DIM; y++)
            send_cell(x, y, (x == ROOM_DIM - 1) || (y == ROOM_DIM - 1)
                            || ($urandom_range(99) < 18));

      // default camera: edges, center and columns past the screen width
      send_cast(0); send_cast(639); send_cast(320); send_cast(640); send_cast(2047);

      // tiny screen, looking along +y
      vals = '{1, 1, 5*65536 + 32768, 5*65536 + 32768, 0, 65536, 43254, 0};
      set_camera(vals);
      send_cast(0); send_cast(1); send_cast(2047);

      // width and height that wrap to zero, eye in the corner cell
      vals = '{4096, 4096, 0, 0, -131072, -131072, 131072, 131072};
      set_camera(vals);
      send_cast(0); send_cast(1); send_cast(1000);

      // widest settings, eye at the far corner of the room
      vals = '{4095, 4095, EYE_MAX, EYE_MAX, 131072, 131072, -131072, -131072};
      set_camera(vals);
      send_cast(0); send_cast(2047); send_cast(1024);

      // zero ray and a wall under the eye
      vals = '{2, 2048, 10*65536, 10*65536, 0, 0, 0, 0};
      set_camera(vals);
      send_cell(10, 10, 1);
      send_cast(0); send_cast(1);
      send_cell(10, 10, 0);

      // random phases: camera anywhere in the room, mostly casts with some edits
      for (int ph = 0; ph < 7; ph++) begin
         vals[0] = $urandom_range(99) < 70 ? $urandom_range(1, 1024) : $urandom_range(1, 4095);
         vals[1] = $urandom_range(99) < 70 ? $urandom_range(1, 1024) : $urandom_range(0, 4095);
         vals[2] = $urandom_range(EYE_MAX);
         vals[3] = $urandom_range(EYE_MAX);
         vals[4] = rnd_signed(131072);
         vals[5] = rnd_signed(131072);
         vals[6] = rnd_signed(131072);
         vals[7] = rnd_signed(131072);
         set_camera(vals);
         no_idle = (ph == 2);
         for (int i = 0; i < 56; i++) begin
            // fill the block while the receiver holds off
            if (ph == 4 && i == 10) holdoff = HOLDOFF_CYCLES;
            if ($urandom_range(99) < 30)
               send_cell($urandom_range(ROOM_DIM - 2), $urandom_range(ROOM_DIM - 2),
                         $urandom_range(99) < 18);
            else
               random_column_cast();
         end
         no_idle = 0;
      end

      // drain and settle
      req_valid <= 1'b0;
      while (sb.expected_cols.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);

      $display("covered %0d casts (%0d escaped) and %0d map cell writes",
               sb.casts_seen, sb.escapes_seen, sb.cells_written);
      $display("camera settings: reset, extremes, zero ray, seven random phases");
      if (sb.mismatches == 0 && sb.expected_cols.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/grc_pkg.sv
rtl/grc_div.sv
rtl/grc_datapath.sv
rtl/grc_ctrl.sv
rtl/grid_ray_caster_column_top.sv
bench/tb_grid_ray_caster_column_top.sv
